// ===== hw/rtl/dda_pkg.sv =====
// Shared types and constants for the DDA line rasterizer.
package dda_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_PIXEL = 1'b1
    } item_kind_t;

    typedef enum logic {
        BK_RUN = 1'b0,
        BK_DIV = 1'b1
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hw/rtl/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer: front end, queue and back end.
//
// Input stream (s_): s_tuser is the mode. Mode 0 loads a line from s_tdata
// (start_x, start_y, end_x, end_y from the low bits up) and emits nothing.
// Mode 1 requests the next pixel of the loaded line; with no line active it
// is consumed and emits nothing.
// Output stream (m_): m_tdata carries pixel_x, pixel_y from the low bits up;
// m_tlast marks the final one of the steps+1 pixels of a line.
// Throughput: pixel requests run at one per clock while the output register is
// free and no load is in the divider. A load holds the back end while the shared
// restoring divider forms both increments, one quotient bit per cycle.
// A pixel request passes the queue register, then the output register, on its
// way to m_.
// A two-entry queue separates input acceptance from execution, so s_tready
// stays high while the back end is busy until the queue fills.
// When m_tready is low the pixel holds in the output register; further
// requests wait in the queue and then back-pressure s_tready.
// Reset (aresetn low, synchronous) empties the queue, drops any line in
// progress and clears m_tvalid.
module dda_line_rasterizer #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
    parameter int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
    parameter int OUT_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // start_x, start_y, end_x, end_y
    input  logic              s_tuser,   // mode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // pixel_x, pixel_y
    output logic              m_tlast    // last_pixel
);
    import dda_pkg::*;

    localparam int ENTRY_W = 5 * COORD_BITS + 3;

    q_status_t              q_status;
    logic                   q_push, q_pop;
    logic [ENTRY_W-1:0]     q_in, q_head;
    logic [COORD_BITS-1:0]  pixel_x, pixel_y;

    dda_front #(
        .COORD_BITS (COORD_BITS),
        .IN_W       (IN_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    dda_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head_data (q_head),
        .status    (q_status)
    );

    dda_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_entry    (q_head),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (m_tlast)
    );

    assign m_tdata = OUT_W'({pixel_y, pixel_x});

endmodule

// ===== hw/rtl/dda_front.sv =====
// Front end: accepts input transactions, classifies them and precomputes line deltas.
module dda_front #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
    parameter int ENTRY_W    = 5 * COORD_BITS + 3
) (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // start_x, start_y, end_x, end_y
    input  logic                  s_tuser,   // mode
    input  dda_pkg::q_status_t    q_status,
    output logic                  q_push,
    output logic [ENTRY_W-1:0]    q_entry
);
    import dda_pkg::*;

    localparam int C = COORD_BITS;

    logic [C-1:0]        start_x, start_y, end_x, end_y;
    logic signed [C:0]   dx, dy;
    logic [C:0]          dx_abs, dy_abs;
    logic [C-1:0]        mag_x, mag_y, steps;
    logic                neg_x, neg_y;
    item_kind_t          kind;

    always_comb begin
        start_x = s_tdata[0     +: C];
        start_y = s_tdata[C     +: C];
        end_x   = s_tdata[2 * C +: C];
        end_y   = s_tdata[3 * C +: C];
        dx      = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
        dy      = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
        neg_x   = dx[C];
        neg_y   = dy[C];
        dx_abs  = neg_x ? (-dx) : dx;
        dy_abs  = neg_y ? (-dy) : dy;
        mag_x   = dx_abs[C-1:0];
        mag_y   = dy_abs[C-1:0];
        steps   = (mag_x > mag_y) ? mag_x : mag_y;
        kind    = s_tuser ? KIND_PIXEL : KIND_LOAD;
    end

    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid && !q_status.full;
    assign q_entry  = {logic'(kind), start_x, start_y, mag_x, mag_y, neg_x, neg_y, steps};

endmodule

// ===== hw/rtl/dda_queue.sv =====
// Short register FIFO between the front end and the back end.
module dda_queue #(
    parameter int WIDTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   head_data,
    output dda_pkg::q_status_t status
);
    import dda_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_data    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.full && !pop) |=> (count_reg == CNT_W'(DEPTH)))
        else $error("queue count changed while full and not popped");

endmodule

// ===== hw/rtl/dda_div.sv =====
// Radix-2 restoring divider producing both signed per-step increments.
module dda_div #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [COORD_BITS-1:0]        divisor,
    input  logic [COORD_BITS-1:0]        mag_x,
    input  logic [COORD_BITS-1:0]        mag_y,
    input  logic                         neg_x,
    input  logic                         neg_y,
    output logic                         done,
    output logic signed [FRAC_BITS+1:0]  step_x,
    output logic signed [FRAC_BITS+1:0]  step_y
);
    import dda_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int RW  = C + 1;
    localparam int QW  = F + 1;
    localparam int SW  = F + 2;
    localparam int CW  = $clog2(F + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [QW-1:0] q_x_reg, q_x_next, q_y_reg, q_y_next;
    logic [C-1:0]  div_reg, div_next;
    logic          neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic          zero_reg, zero_next;

    logic [RW-1:0] dv, r2_x, r2_y;
    logic          ge_x, ge_y, ge0_x, ge0_y;
    logic [SW-1:0] qe_x, qe_y;

    always_comb begin
        dv    = {1'b0, div_reg};
        r2_x  = {rem_x_reg[C-1:0], 1'b0};
        r2_y  = {rem_y_reg[C-1:0], 1'b0};
        ge_x  = (r2_x >= dv);
        ge_y  = (r2_y >= dv);
        ge0_x = (mag_x >= divisor);
        ge0_y = (mag_y >= divisor);

        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        q_x_next   = q_x_reg;
        q_y_next   = q_y_reg;
        div_next   = div_reg;
        neg_x_next = neg_x_reg;
        neg_y_next = neg_y_reg;
        zero_next  = zero_reg;

        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = CW'(F);
            div_next   = divisor;
            neg_x_next = neg_x;
            neg_y_next = neg_y;
            zero_next  = (divisor == '0);
            rem_x_next = ge0_x ? ({1'b0, mag_x} - {1'b0, divisor}) : {1'b0, mag_x};
            rem_y_next = ge0_y ? ({1'b0, mag_y} - {1'b0, divisor}) : {1'b0, mag_y};
            q_x_next   = QW'(ge0_x);
            q_y_next   = QW'(ge0_y);
        end else if (busy_reg) begin
            rem_x_next = ge_x ? (r2_x - dv) : r2_x;
            rem_y_next = ge_y ? (r2_y - dv) : r2_y;
            q_x_next   = {q_x_reg[QW-2:0], ge_x};
            q_y_next   = {q_y_reg[QW-2:0], ge_y};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        q_x_reg   <= q_x_next;
        q_y_reg   <= q_y_next;
        div_reg   <= div_next;
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
        zero_reg  <= zero_next;
    end

    // zero divisor only happens with zero deltas: both increments are zero
    assign qe_x   = {1'b0, q_x_reg};
    assign qe_y   = {1'b0, q_y_reg};
    assign step_x = zero_reg ? '0 : (neg_x_reg ? $signed(-qe_x) : $signed(qe_x));
    assign step_y = zero_reg ? '0 : (neg_y_reg ? $signed(-qe_y) : $signed(qe_y));
    assign done   = done_reg;

endmodule

// ===== hw/rtl/dda_back.sv =====
// Back end: runs line loads through the divider and steps out pixels.
module dda_back #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
    parameter int ENTRY_W    = 5 * COORD_BITS + 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [ENTRY_W-1:0]     q_entry,
    input  dda_pkg::q_status_t     q_status,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COORD_BITS-1:0]  pixel_x,
    output logic [COORD_BITS-1:0]  pixel_y,
    output logic                   last_pixel
);
    import dda_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = C + F + 1;
    localparam int SW = F + 2;

    back_state_t           state_reg, state_next;
    logic signed [PW-1:0]  pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [SW-1:0]  step_x_reg, step_x_next, step_y_reg, step_y_next;
    logic [C:0]            left_reg, left_next;
    logic                  active_reg, active_next;
    logic                  m_valid_reg, m_valid_next;
    logic [C-1:0]          px_reg, px_next, py_reg, py_next;
    logic                  last_reg, last_next;

    item_kind_t            head_kind;
    logic [C-1:0]          e_start_x, e_start_y, e_mag_x, e_mag_y, e_steps;
    logic                  e_neg_x, e_neg_y;
    logic                  out_free, emit, load, div_start, div_done;
    logic signed [SW-1:0]  div_step_x, div_step_y;

    always_comb begin
        e_steps   = q_entry[0 +: C];
        e_neg_y   = q_entry[C];
        e_neg_x   = q_entry[C + 1];
        e_mag_y   = q_entry[C + 2     +: C];
        e_mag_x   = q_entry[2 * C + 2 +: C];
        e_start_y = q_entry[3 * C + 2 +: C];
        e_start_x = q_entry[4 * C + 2 +: C];
        head_kind = item_kind_t'(q_entry[ENTRY_W-1]);
    end

    dda_div #(
        .COORD_BITS (C),
        .FRAC_BITS  (F)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (e_steps),
        .mag_x   (e_mag_x),
        .mag_y   (e_mag_y),
        .neg_x   (e_neg_x),
        .neg_y   (e_neg_y),
        .done    (div_done),
        .step_x  (div_step_x),
        .step_y  (div_step_y)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN: begin
                if (!q_status.empty && head_kind == KIND_LOAD) begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        load      = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            BK_RUN: begin
                if (!q_status.empty) begin
                    if (head_kind == KIND_LOAD) begin
                        q_pop     = 1'b1;
                        load      = 1'b1;
                        div_start = 1'b1;
                    end else if (!active_reg) begin
                        q_pop = 1'b1;
                    end else if (out_free) begin
                        q_pop = 1'b1;
                        emit  = 1'b1;
                    end
                end
            end
            BK_DIV: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        left_next    = left_reg;
        active_next  = active_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        last_next    = last_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;

        if (load) begin
            pos_x_next  = $signed({1'b0, e_start_x, {F{1'b0}}});
            pos_y_next  = $signed({1'b0, e_start_y, {F{1'b0}}});
            left_next   = {1'b0, e_steps} + 1'b1;
            active_next = 1'b1;
        end
        if (div_done) begin
            step_x_next = div_step_x;
            step_y_next = div_step_y;
        end
        if (emit) begin
            px_next      = pos_x_reg[F +: C];
            py_next      = pos_y_reg[F +: C];
            last_next    = (left_reg == (C + 1)'(1));
            m_valid_next = 1'b1;
            pos_x_next   = pos_x_reg + {{(PW - SW){step_x_reg[SW-1]}}, step_x_reg};
            pos_y_next   = pos_y_reg + {{(PW - SW){step_y_reg[SW-1]}}, step_y_reg};
            left_next    = left_reg - 1'b1;
            if (left_reg == (C + 1)'(1)) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_RUN;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            step_x_reg  <= '0;
            step_y_reg  <= '0;
            left_reg    <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            step_x_reg  <= step_x_next;
            step_y_reg  <= step_y_next;
            left_reg    <= left_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        last_reg <= last_next;
    end

    assign m_valid    = m_valid_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign last_pixel = last_reg;

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == BK_DIV))
        else $error("divider finished outside of a load");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && left_reg == (C + 1)'(1)) |=> (!active_reg && last_pixel))
        else $error("line still active after its last pixel");

    a_no_emit_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DIV) |-> !emit)
        else $error("pixel emitted while a load is in the divider");

endmodule

// ===== verif/dda_line_rasterizer_tb.sv =====
// Self-checking testbench for the DDA line rasterizer: directed and random line streams.
module dda_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dda_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int FB          = FRAC_BITS_DEF;
    localparam int IN_W        = ((4 * CB + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * CB + 7) / 8) * 8;
    localparam int COORD_MAX   = (1 << CB) - 1;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          last;
    } pixel_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;   // start_x, start_y, end_x, end_y
    logic              s_tuser = KIND_LOAD;   // mode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;   // pixel_x, pixel_y
    logic              m_tlast;

    // rasterizer state as predicted
    logic signed [CB+FB:0] pos_x = '0, pos_y = '0;
    logic signed [FB+1:0]  step_x = '0, step_y = '0;
    logic [CB:0]           pixels_left = '0;
    logic                  line_active = 1'b0;

    pixel_t pixel_expect[$];
    int     errors = 0;
    bit     tx_burst = 1'b0;
    int     rx_hold = 0;
    pixel_t want;

    dda_line_rasterizer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic signed [FB+1:0] increment(longint delta, longint steps);
        if (steps == 0) return '0;
        return (FB + 2)'((delta * (longint'(1) << FB)) / steps);
    endfunction

    // advance the predicted rasterizer by one accepted transaction
    task automatic predict_pixel(input item_kind_t kind, input logic [IN_W-1:0] data);
        longint sx, sy, ex, ey, dx, dy, adx, ady, steps;
        pixel_t px;
        if (kind == KIND_LOAD) begin
            sx = data[CB-1:0];
            sy = data[2*CB-1:CB];
            ex = data[3*CB-1:2*CB];
            ey = data[4*CB-1:3*CB];
            dx = ex - sx;
            dy = ey - sy;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            steps = (adx > ady) ? adx : ady;
            step_x = increment(dx, steps);
            step_y = increment(dy, steps);
            pos_x = (CB + FB + 1)'(sx << FB);
            pos_y = (CB + FB + 1)'(sy << FB);
            pixels_left = (CB + 1)'(steps + 1);
            line_active = 1'b1;
        end else if (line_active) begin
            px.x = pos_x[FB+CB-1:FB];
            px.y = pos_y[FB+CB-1:FB];
            pos_x = pos_x + step_x;
            pos_y = pos_y + step_y;
            pixels_left = pixels_left - 1'b1;
            px.last = (pixels_left == 0);
            if (px.last) line_active = 1'b0;
            pixel_expect.push_back(px);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (tx_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input item_kind_t kind, input logic [IN_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        predict_pixel(kind, data);
    endtask

    task automatic load_line(input int sx, input int sy, input int ex, input int ey);
        logic [IN_W-1:0] d;
        d = '0;
        d[CB-1:0]      = CB'(sx);
        d[2*CB-1:CB]   = CB'(sy);
        d[3*CB-1:2*CB] = CB'(ex);
        d[4*CB-1:3*CB] = CB'(ey);
        send_item(KIND_LOAD, d);
    endtask

    task automatic request_pixel();
        send_item(KIND_PIXEL, IN_W'({$urandom, $urandom}));
    endtask

    task automatic note_failure(input string msg);
        if (errors < 10) $display("%s", msg);
        errors++;
    endtask

    function automatic int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // result side: check each transaction, then pick the next ready pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_expect.size() == 0) begin
                note_failure($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                    m_tdata[CB-1:0], m_tdata[2*CB-1:CB], m_tlast));
            end else begin
                want = pixel_expect.pop_front();
                if (m_tdata[CB-1:0] !== want.x || m_tdata[2*CB-1:CB] !== want.y ||
                    m_tlast !== want.last)
                    note_failure($sformatf(
                        "pixel mismatch: exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                        want.x, want.y, want.last,
                        m_tdata[CB-1:0], m_tdata[2*CB-1:CB], m_tlast));
            end
        end
        if (rx_hold == 0) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                    m_tready <= 1'b1;
                    rx_hold = $urandom_range(1, 20);
                end
                9: begin
                    m_tready <= 1'b1;
                    rx_hold = $urandom_range(50, 150);
                end
                18, 19: begin
                    m_tready <= 1'b0;
                    rx_hold = $urandom_range(10, 40);
                end
                default: begin
                    m_tready <= 1'b0;
                    rx_hold = $urandom_range(1, 3);
                end
            endcase
        end else begin
            rx_hold--;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic test_no_line();
        request_pixel();
    endtask

    task automatic test_single_point();
        load_line(5, 7, 5, 7);
        request_pixel();
        request_pixel();
    endtask

    // full-range diagonals, each later load cutting off the line in progress
    task automatic test_diagonals();
        load_line(0, 0, COORD_MAX, COORD_MAX);
        repeat (3) request_pixel();
        load_line(COORD_MAX, COORD_MAX, 0, 0);
        repeat (3) request_pixel();
        load_line(COORD_MAX, 0, 0, COORD_MAX);
        repeat (2) request_pixel();
    endtask

    // fractional step stops one short of the end point
    task automatic test_undershoot();
        load_line(10, 20, 12, 15);
        repeat (7) request_pixel();
    endtask

    task automatic test_long_line();
        tx_burst = 1'b0;
        load_line(3, 600, 130, 500);
        repeat (128) request_pixel();
    endtask

    task automatic test_random_lines();
        int counted, sx, sy, ex, ey, adx, ady, steps, span, reqs, r;
        counted = 0;
        while (counted < 540) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            sx = $urandom_range(0, COORD_MAX);
            sy = $urandom_range(0, COORD_MAX);
            r = $urandom_range(0, 99);
            if (r < 70) span = 8;
            else if (r < 92) span = 40;
            else span = 0;
            if (span == 0) begin
                ex = $urandom_range(0, COORD_MAX);
                ey = $urandom_range(0, COORD_MAX);
            end else begin
                ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
                ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
            end
            adx = (ex > sx) ? ex - sx : sx - ex;
            ady = (ey > sy) ? ey - sy : sy - ey;
            steps = (adx > ady) ? adx : ady;
            r = $urandom_range(0, 99);
            if (span == 0) reqs = $urandom_range(0, 30);
            else if (r < 75) reqs = steps + 1;
            else if (r < 88) reqs = steps + 1 + $urandom_range(1, 3);
            else reqs = $urandom_range(0, steps);
            load_line(sx, sy, ex, ey);
            counted++;
            repeat (reqs) begin
                counted++;
                request_pixel();
            end
        end
        tx_burst = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_no_line();
        test_single_point();
        test_diagonals();
        test_undershoot();
        test_long_line();
        test_random_lines();
        s_tvalid <= 1'b0;
        while (pixel_expect.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
